// ===== rtl/vtpd_pkg.sv =====
package vtpd_pkg;

	localparam int WORD_W             = 32;
	localparam int IDX_W              = 4;
	localparam int MAT_WORDS          = 16;
	localparam int MAT_DIM            = 4;
	localparam int DEFAULT_FRAC_BITS  = 16;
	localparam int DIV_BITS_PER_STAGE = 4;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_XFORM = 1'b1;

	typedef struct packed {
		logic                     func;
		logic [IDX_W-1:0]         entry_index;
		logic signed [WORD_W-1:0] entry_value;
		logic signed [WORD_W-1:0] in_x;
		logic signed [WORD_W-1:0] in_y;
		logic signed [WORD_W-1:0] in_z;
		logic signed [WORD_W-1:0] in_w;
	} vin_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] out_x;
		logic signed [WORD_W-1:0] out_y;
		logic signed [WORD_W-1:0] out_z;
		logic signed [WORD_W-1:0] out_w;
		logic                     was_divided;
		logic                     saturated;
	} vout_t;

endpackage

// ===== rtl/vtpd_stream_if.sv =====
interface vtpd_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/vertex_transform_perspective_divide.sv =====
// Registered path: products, column sums, clamped sums, divider entry and stages, output.
// Throughput: one vertex or matrix load per cycle unless stalled; 4-bit-per-stage divider.
// Matrix loads take effect at once and produce no result; they never enter the pipeline.
// The whole pipeline advances together and holds while the output register is stalled.
// Reset (arst_n, async, active low) clears all valid bits; matrix words are undefined until loaded.
module vertex_transform_perspective_divide import vtpd_pkg::*; #(
	parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
	input logic          clk,
	input logic          arst_n,
	vtpd_stream_if.sink   vin,
	vtpd_stream_if.source vout
);

	localparam int PROD_W     = 2 * WORD_W;
	localparam int SUM_W      = PROD_W + 2;
	localparam int NUM_W      = WORD_W + FRAC_BITS;
	localparam int DIV_STAGES = (NUM_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
	localparam int NQ_W       = DIV_STAGES * DIV_BITS_PER_STAGE;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {{(SUM_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
	localparam logic [NQ_W-1:0] Q_POS_MAX = NQ_W'({(WORD_W-1){1'b1}});
	localparam logic [NQ_W-1:0] Q_NEG_MAX = NQ_W'({1'b1, {(WORD_W-1){1'b0}}});
	localparam logic signed [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic signed [WORD_W-1:0] ONE   = WORD_W'(1) << FRAC_BITS;

	logic adv;
	logic load_fire;
	logic signed [WORD_W-1:0] mat_q [MAT_WORDS];
	logic signed [WORD_W-1:0] vec [MAT_DIM];

	logic v_s1, v_s2, v_s3;
	logic signed [PROD_W-1:0] prod_s1 [MAT_DIM][MAT_DIM];
	logic signed [SUM_W-1:0]  sum_s2 [MAT_DIM];
	logic signed [SUM_W-1:0]  shr [MAT_DIM];
	logic signed [WORD_W-1:0] res_c [MAT_DIM];
	logic [MAT_DIM-1:0]       sat_c;
	logic signed [WORD_W-1:0] res_s3 [MAT_DIM];
	logic                     sat_s3;

	// divider pipeline: index 0 is the entry stage
	logic [DIV_STAGES:0]      dv_s;
	logic [NQ_W-1:0]          nq_s   [DIV_STAGES+1][3];
	logic [WORD_W-1:0]        rem_s  [DIV_STAGES+1][3];
	logic [WORD_W-1:0]        dvs_s  [DIV_STAGES+1];
	logic [2:0]               neg_s  [DIV_STAGES+1];
	logic signed [WORD_W-1:0] raw_s  [DIV_STAGES+1][MAT_DIM];
	logic                     div_s  [DIV_STAGES+1];
	logic                     sat_ds [DIV_STAGES+1];

	logic [NQ_W-1:0]          nq_nx  [1:DIV_STAGES][3];
	logic [WORD_W-1:0]        rem_nx [1:DIV_STAGES][3];

	logic [WORD_W-1:0] abs_c [MAT_DIM];
	logic              ov_q;
	vout_t             od_q;
	vout_t             od_nx;
	logic [NQ_W-1:0]   qf [3];
	logic signed [WORD_W-1:0] qv [3];
	logic [2:0]        qsat;

	assign adv       = !ov_q || vout.ready;
	assign vin.ready = adv;
	assign load_fire = vin.valid && adv && (vin.data.func == FUNC_LOAD);

	assign vec[0] = vin.data.in_x;
	assign vec[1] = vin.data.in_y;
	assign vec[2] = vin.data.in_z;
	assign vec[3] = vin.data.in_w;

	always_ff @(posedge clk) begin
		if (load_fire) begin
			mat_q[vin.data.entry_index] <= vin.data.entry_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			dv_s <= '0;
			ov_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= vin.valid && (vin.data.func == FUNC_XFORM);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			dv_s <= {dv_s[DIV_STAGES-1:0], v_s3};
			ov_q <= dv_s[DIV_STAGES];
		end
	end

	// stage 3: floor shift and clamp of the column sums
	always_comb begin
		for (int c = 0; c < MAT_DIM; c++) begin
			shr[c]   = sum_s2[c] >>> FRAC_BITS;
			sat_c[c] = 1'b0;
			if (shr[c] > SUM_MAX) begin
				res_c[c] = W_MAX;
				sat_c[c] = 1'b1;
			end else if (shr[c] < SUM_MIN) begin
				res_c[c] = W_MIN;
				sat_c[c] = 1'b1;
			end else begin
				res_c[c] = shr[c][WORD_W-1:0];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < MAT_DIM; c++) begin
			abs_c[c] = res_s3[c][WORD_W-1] ? WORD_W'(-res_s3[c]) : WORD_W'(res_s3[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < MAT_DIM; r++) begin
				for (int c = 0; c < MAT_DIM; c++) begin
					prod_s1[r][c] <= PROD_W'(vec[r]) * PROD_W'(mat_q[IDX_W'(r * MAT_DIM + c)]);
				end
			end
			for (int c = 0; c < MAT_DIM; c++) begin
				sum_s2[c] <= SUM_W'(prod_s1[0][c]) + SUM_W'(prod_s1[1][c])
					+ SUM_W'(prod_s1[2][c]) + SUM_W'(prod_s1[3][c]);
				res_s3[c] <= res_c[c];
			end
			sat_s3 <= |sat_c;

			// divider entry: magnitudes and quotient signs
			dvs_s[0]  <= abs_c[3];
			div_s[0]  <= res_s3[3] != '0;
			sat_ds[0] <= sat_s3;
			for (int c = 0; c < 3; c++) begin
				nq_s[0][c]  <= NQ_W'({abs_c[c], {FRAC_BITS{1'b0}}});
				rem_s[0][c] <= '0;
				neg_s[0][c] <= res_s3[c][WORD_W-1] ^ res_s3[3][WORD_W-1];
			end
			for (int c = 0; c < MAT_DIM; c++) begin
				raw_s[0][c] <= res_s3[c];
			end
			od_q <= od_nx;
		end
	end

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		logic [WORD_W:0] t [3];

		// restoring division, DIV_BITS_PER_STAGE quotient bits per stage
		always_comb begin
			for (int c = 0; c < 3; c++) begin
				nq_nx[k][c]  = nq_s[k-1][c];
				rem_nx[k][c] = rem_s[k-1][c];
				t[c]         = '0;
				for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
					t[c]        = {rem_nx[k][c], nq_nx[k][c][NQ_W-1]};
					nq_nx[k][c] = nq_nx[k][c] << 1;
					if (t[c] >= {1'b0, dvs_s[k-1]}) begin
						t[c]           = t[c] - {1'b0, dvs_s[k-1]};
						nq_nx[k][c][0] = 1'b1;
					end
					rem_nx[k][c] = t[c][WORD_W-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dvs_s[k]  <= dvs_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				div_s[k]  <= div_s[k-1];
				sat_ds[k] <= sat_ds[k-1];
				for (int c = 0; c < 3; c++) begin
					nq_s[k][c]  <= nq_nx[k][c];
					rem_s[k][c] <= rem_nx[k][c];
				end
				for (int c = 0; c < MAT_DIM; c++) begin
					raw_s[k][c] <= raw_s[k-1][c];
				end
			end
		end
	end

	// sign fix and clamp of the quotients, and choice of divided or raw result
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qf[c]   = nq_s[DIV_STAGES][c];
			qsat[c] = 1'b0;
			if (neg_s[DIV_STAGES][c]) begin
				if (qf[c] > Q_NEG_MAX) begin
					qv[c]   = W_MIN;
					qsat[c] = 1'b1;
				end else begin
					qv[c] = WORD_W'(-qf[c]);
				end
			end else begin
				if (qf[c] > Q_POS_MAX) begin
					qv[c]   = W_MAX;
					qsat[c] = 1'b1;
				end else begin
					qv[c] = qf[c][WORD_W-1:0];
				end
			end
		end
		if (div_s[DIV_STAGES]) begin
			od_nx.out_x     = qv[0];
			od_nx.out_y     = qv[1];
			od_nx.out_z     = qv[2];
			od_nx.out_w     = ONE;
			od_nx.saturated = sat_ds[DIV_STAGES] || (|qsat);
		end else begin
			od_nx.out_x     = raw_s[DIV_STAGES][0];
			od_nx.out_y     = raw_s[DIV_STAGES][1];
			od_nx.out_z     = raw_s[DIV_STAGES][2];
			od_nx.out_w     = raw_s[DIV_STAGES][3];
			od_nx.saturated = sat_ds[DIV_STAGES];
		end
		od_nx.was_divided = div_s[DIV_STAGES];
	end

	assign vout.valid = ov_q;
	assign vout.data  = od_q;

endmodule

// ===== rtl/vtpd_checker.sv =====
module vtpd_checker import vtpd_pkg::*; #(
	parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WORD_W-1:0] out_x,
	input logic [WORD_W-1:0] out_w,
	input logic              out_was_divided
);

	localparam logic [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x))
		else $error("result changed while stalled");

	a_div_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_was_divided |-> out_w == ONE)
		else $error("divided result without w of one");

	a_nodiv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_was_divided |-> out_w == '0)
		else $error("undivided result with nonzero w");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input blocked while pipeline free");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

endmodule

bind vertex_transform_perspective_divide vtpd_checker #(.FRAC_BITS(FRAC_BITS)) u_vtpd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (vin.valid),
	.in_ready       (vin.ready),
	.out_valid      (vout.valid),
	.out_ready      (vout.ready),
	.out_x          (vout.data.out_x),
	.out_w          (vout.data.out_w),
	.out_was_divided(vout.data.was_divided)
);
